[sv/trre_pkg.sv]
// Package for the timed rule relay engine: sizes, request codes, rule record,
// controller states and the command and status structs. No dependencies.
package trre_pkg;

  localparam int RULES      = 16;
  localparam int MAX_RELAYS = 32;
  localparam int DIN_BITS   = 8;
  localparam int IDX_W      = $clog2(RULES);
  localparam int CNT_W      = $clog2(RULES + 1);
  localparam int REL_W      = $clog2(MAX_RELAYS);
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam logic [15:0] MS_PER_S = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT = 2'd2;

  localparam logic REQ_EVAL  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [1:0] ACT_ON  = 2'd0;
  localparam logic [1:0] ACT_OFF = 2'd1;

  localparam logic [1:0] PRES_PRESENT = 2'd1;
  localparam logic [1:0] PRES_ABSENT  = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [31:0] now_ms;
    logic [7:0]  din_bits;
    logic [1:0]  presence;
    logic [3:0]  rule_index;
    logic        rule_enabled;
    logic [1:0]  rule_trigger;
    logic [1:0]  rule_action;
    logic [2:0]  rule_channel;
    logic [4:0]  rule_target;
    logic [31:0] rule_hold_ms;
    logic [15:0] rule_linger_s;
  } req_t;

  typedef struct packed {
    logic [31:0] relay_bits;
    logic        rule_kept;
  } rsp_t;

  typedef struct packed {
    logic        en;
    logic        src;
    logic        want_inactive;
    logic [1:0]  action;
    logic [2:0]  channel;
    logic [4:0]  target;
    logic [31:0] hold_ms;
    logic [15:0] linger_s;
  } rule_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WRITE, ST_PASS1, ST_PASS2, ST_DONE, ST_OUT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             do_write;
    logic             do_pass1;
    logic             do_pass2;
    logic             finish;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic [CNT_W-1:0] n_rules;
  } sts_t;

endpackage

[sv/trre_if.sv]
// Valid/ready channel interface carrying one payload type.
// The payload types come from trre_pkg at instantiation.
interface trre_if #(type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/timed_rule_relay_engine.sv]
// Timed rule relay engine. An evaluate transaction walks the rules twice, one
// rule per cycle. One transaction is in work at a time and the relay mask
// reports the state after that transaction.
// Depends on trre_pkg, trre_if, trre_ctrl and trre_dp.
module timed_rule_relay_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data,
  trre_if.sink       in_ch,
  trre_if.source     out_ch
);
  import trre_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;

  trre_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  trre_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .req(in_ch.data), .cmd, .sts, .rsp
  );

  assign out_ch.data = rsp;
endmodule

[sv/trre_ctrl.sv]
// Controller of the rule engine: sequences rule writes and the two
// evaluation passes over the table. Depends on trre_pkg.
module trre_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  trre_pkg::sts_t      sts,
  output trre_pkg::cmd_t      cmd
);
  import trre_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WRITE;
          idx_nxt   = '0;
        end
      end
      ST_WRITE: begin
        if (sts.is_write) begin
          cmd.do_write = 1'b1;
          state_nxt    = ST_DONE;
        end else if (sts.n_rules == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PASS1;
        end
      end
      ST_PASS1: begin
        cmd.do_pass1 = 1'b1;
        if ({1'b0, idx_r} == sts.n_rules - 1'b1) begin
          idx_nxt   = '0;
          state_nxt = ST_PASS2;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_PASS2: begin
        cmd.do_pass2 = 1'b1;
        if ({1'b0, idx_r} == sts.n_rules - 1'b1) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

[sv/trre_dp.sv]
// Datapath of the rule engine: rule table, per-rule timing state, relay
// state and result register. Depends on trre_pkg.
module trre_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [5:0]        cfg_data,
  input  trre_pkg::req_t    req,
  input  trre_pkg::cmd_t    cmd,
  output trre_pkg::sts_t    sts,
  output trre_pkg::rsp_t    rsp
);
  import trre_pkg::*;

  rule_t       table_r [RULES];
  logic [RULES-1:0] cact_r, qual_r, ling_r;
  logic [31:0] since_r [RULES];
  logic [31:0] until_r [RULES];
  logic [31:0] relay_r, force_r, force_nxt, request_r, request_nxt;
  logic        kept_r;
  req_t        req_r;
  logic [4:0]  rule_count_r;
  logic [5:0]  relay_count_r;
  logic [3:0]  input_count_r;
  logic [CNT_W-1:0] n_rules;
  logic [6:0]  nrel;

  rule_t       ru, wr;
  logic        in_range, met, was, q, cact_n, qual_n, ling_n, bit_v;
  logic [31:0] since_n, until_n, held, ldiff;
  logic [31:0] delay_ms;

  assign n_rules = (rule_count_r > 5'(RULES)) ? CNT_W'(RULES) : CNT_W'(rule_count_r);
  assign nrel    = (relay_count_r > 6'(MAX_RELAYS)) ? 7'(MAX_RELAYS) : {1'b0, relay_count_r};
  assign sts.is_write = req_r.req_type == REQ_WRITE;
  assign sts.n_rules  = n_rules;
  assign rsp.relay_bits = relay_r;
  assign rsp.rule_kept  = kept_r;

  assign ru       = table_r[cmd.idx];
  assign in_range = ru.en && ({2'b0, ru.target} < nrel);
  assign bit_v    = (32'(ru.channel) < 32'(DIN_BITS)) && req_r.din_bits[ru.channel];
  assign delay_ms = 32'(ru.linger_s) * 32'(MS_PER_S);
  assign held     = req_r.now_ms - since_r[cmd.idx];

  always_comb begin
    if (ru.src == 1'b0) begin
      met = ru.want_inactive ? (req_r.presence == PRES_ABSENT) :
                               (req_r.presence == PRES_PRESENT);
    end else begin
      met = ru.want_inactive ? !bit_v : bit_v;
    end
    cact_n  = cact_r[cmd.idx];
    qual_n  = qual_r[cmd.idx];
    ling_n  = ling_r[cmd.idx];
    since_n = since_r[cmd.idx];
    until_n = until_r[cmd.idx];
    was     = qual_r[cmd.idx];
    q       = 1'b0;
    ldiff   = '0;
    force_nxt   = force_r;
    request_nxt = request_r;
    if (!in_range) begin
      cact_n = 1'b0; qual_n = 1'b0; ling_n = 1'b0;
      since_n = '0; until_n = '0;
    end else begin
      if (met) begin
        if (!cact_r[cmd.idx]) begin
          cact_n  = 1'b1;
          since_n = req_r.now_ms;
        end
        q = (cact_r[cmd.idx] ? held : 32'd0) >= ru.hold_ms;
        qual_n = q;
        if (q && ru.action == ACT_ON) ling_n = 1'b0;
      end else begin
        cact_n = 1'b0;
        qual_n = 1'b0;
        if (ru.action == ACT_ON && was) begin
          if (ru.linger_s != '0) begin
            ling_n  = 1'b1;
            until_n = req_r.now_ms + delay_ms;
          end else begin
            ling_n = 1'b0;
          end
        end
      end
      ldiff = req_r.now_ms - until_n;
      if (ru.action == ACT_OFF && qual_n) force_nxt[ru.target] = 1'b1;
      if (ru.action == ACT_ON) begin
        if (ling_n && !ldiff[31]) ling_n = 1'b0;
        if (qual_n || ling_n) request_nxt[ru.target] = 1'b1;
      end
    end
  end

  always_comb begin
    wr.en            = req_r.rule_enabled;
    wr.src           = req_r.rule_trigger[0];
    wr.want_inactive = req_r.rule_trigger[1];
    wr.action        = req_r.rule_action;
    wr.channel       = req_r.rule_channel;
    wr.target        = req_r.rule_target;
    wr.hold_ms       = req_r.rule_hold_ms;
    wr.linger_s      = req_r.rule_linger_s;
    if (wr.action > ACT_OFF) wr.en = 1'b0;
    if (wr.src && ({1'b0, wr.channel} >= input_count_r)) wr.en = 1'b0;
    if ({2'b0, wr.target} >= nrel) wr.en = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r  <= '0;
      relay_count_r <= '0;
      input_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RULE_COUNT:  rule_count_r  <= cfg_data[4:0];
        CFG_RELAY_COUNT: relay_count_r <= cfg_data;
        CFG_INPUT_COUNT: input_count_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RULES; i++) begin
        table_r[i] <= '0;
        since_r[i] <= '0;
        until_r[i] <= '0;
      end
      cact_r    <= '0;
      qual_r    <= '0;
      ling_r    <= '0;
      relay_r   <= '0;
      force_r   <= '0;
      request_r <= '0;
      kept_r    <= 1'b0;
    end else begin
      if (cmd.load) begin
        force_r   <= '0;
        request_r <= '0;
        kept_r    <= 1'b0;
      end
      if (cmd.do_write) begin
        table_r[req_r.rule_index] <= wr;
        kept_r <= wr.en;
      end
      if (cmd.do_pass1) begin
        cact_r[cmd.idx]  <= cact_n;
        qual_r[cmd.idx]  <= qual_n;
        ling_r[cmd.idx]  <= ling_n;
        since_r[cmd.idx] <= since_n;
        until_r[cmd.idx] <= until_n;
        force_r   <= force_nxt;
        request_r <= request_nxt;
      end
      if (cmd.do_pass2) begin
        if (ru.en && ru.action == ACT_ON && ({2'b0, ru.target} < nrel) &&
            force_r[ru.target]) begin
          ling_r[cmd.idx]  <= 1'b0;
          until_r[cmd.idx] <= '0;
        end
      end
      if (cmd.finish && !sts.is_write) begin
        relay_r <= request_r & ~force_r;
      end
    end
  end
endmodule

[bench/timed_rule_relay_engine_tb.sv]
`timescale 1ns / 100ps
// Testbench for timed_rule_relay_engine: directed table, then random rule writes and
// evaluate ticks, each result checked against a predictor. Depends on trre_pkg and trre_if.
module timed_rule_relay_engine_tb;
  import trre_pkg::*;

  localparam logic [1:0] TRIG_PRES_ACT = 2'd0;
  localparam logic [1:0] TRIG_DIN_ACT  = 2'd1;
  localparam logic [1:0] TRIG_PRES_OFF = 2'd2;
  localparam logic [1:0] TRIG_DIN_OFF  = 2'd3;
  localparam logic [1:0] ACT_BAD2      = 2'd2;
  localparam logic [1:0] ACT_BAD3      = 2'd3;
  localparam logic [1:0] PRES_UNKNOWN  = 2'd0;
  localparam logic [1:0] PRES_HERE     = 2'd1;
  localparam logic [1:0] PRES_AWAY     = 2'd2;
  localparam logic [1:0] PRES_BAD      = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t e;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;

  trre_if #(.T(req_t)) in_ch ();
  trre_if #(.T(rsp_t)) out_ch ();

  timed_rule_relay_engine u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  rule_t       m_rules [RULES];
  bit          m_cact [RULES];
  bit [31:0]   m_since [RULES];
  bit          m_qual [RULES];
  bit          m_ling [RULES];
  bit [31:0]   m_until [RULES];
  bit [31:0]   m_relays;
  bit [4:0]    m_rule_cnt;
  bit [5:0]    m_relay_cnt;
  bit [3:0]    m_input_cnt;

  rsp_t expected_rsp[$];
  int errors = 0;
  int cycles = 0;
  bit [31:0] now_t = 0;
  logic [7:0] cur_din = 0;
  logic [1:0] cur_pres = PRES_UNKNOWN;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic void clear_rule_state(int i);
    m_cact[i] = 0;
    m_qual[i] = 0;
    m_since[i] = 0;
    m_ling[i] = 0;
    m_until[i] = 0;
  endfunction

  function automatic bit condition_holds(rule_t ru, logic [7:0] din, logic [1:0] pres);
    bit act;
    if (!ru.src) return ru.want_inactive ? (pres == PRES_AWAY) : (pres == PRES_HERE);
    act = din[ru.channel];
    return ru.want_inactive ? !act : act;
  endfunction

  function automatic rsp_t predict_relays(req_t q);
    rsp_t res;
    bit [31:0] force_m, request_m, mask, ldiff;
    int n, nrel;
    bit was, qual;
    rule_t ru;
    force_m = 0;
    request_m = 0;
    mask = 0;
    n = (m_rule_cnt > RULES) ? RULES : m_rule_cnt;
    nrel = (m_relay_cnt > MAX_RELAYS) ? MAX_RELAYS : m_relay_cnt;
    res.rule_kept = 0;
    if (q.req_type == REQ_EVAL) begin
      for (int i = 0; i < n; i++) begin
        ru = m_rules[i];
        if (!ru.en || ru.target >= nrel) begin
          clear_rule_state(i);
          continue;
        end
        if (condition_holds(ru, q.din_bits, q.presence)) begin
          if (!m_cact[i]) begin
            m_cact[i] = 1;
            m_since[i] = q.now_ms;
          end
          qual = (q.now_ms - m_since[i]) >= ru.hold_ms;
          m_qual[i] = qual;
          if (qual && ru.action == ACT_ON) m_ling[i] = 0;
        end else begin
          was = m_qual[i];
          m_cact[i] = 0;
          m_qual[i] = 0;
          if (ru.action == ACT_ON && was) begin
            if (ru.linger_s != 0) begin
              m_ling[i] = 1;
              m_until[i] = q.now_ms + 32'(ru.linger_s) * 32'd1000;
            end else begin
              m_ling[i] = 0;
            end
          end
        end
        if (ru.action == ACT_OFF && m_qual[i]) force_m[ru.target] = 1;
        if (ru.action == ACT_ON) begin
          ldiff = q.now_ms - m_until[i];
          if (m_ling[i] && !ldiff[31]) m_ling[i] = 0;
          if (m_qual[i] || m_ling[i]) request_m[ru.target] = 1;
        end
      end
      for (int r = 0; r < nrel; r++) begin
        if (force_m[r]) begin
          for (int i = 0; i < n; i++) begin
            if (m_rules[i].en && m_rules[i].action == ACT_ON && m_rules[i].target == r) begin
              m_ling[i] = 0;
              m_until[i] = 0;
            end
          end
        end else if (request_m[r]) begin
          mask[r] = 1;
        end
      end
      m_relays = mask;
    end else begin
      ru.en = q.rule_enabled;
      ru.src = q.rule_trigger[0];
      ru.want_inactive = q.rule_trigger[1];
      ru.action = q.rule_action;
      ru.channel = q.rule_channel;
      ru.target = q.rule_target;
      ru.hold_ms = q.rule_hold_ms;
      ru.linger_s = q.rule_linger_s;
      if (ru.action > ACT_OFF) ru.en = 0;
      if (ru.src && ru.channel >= m_input_cnt) ru.en = 0;
      if (ru.target >= nrel) ru.en = 0;
      m_rules[q.rule_index] = ru;
      res.rule_kept = ru.en;
    end
    res.relay_bits = m_relays;
    return res;
  endfunction

  function automatic req_t ev(logic [31:0] t, logic [7:0] din, logic [1:0] pres);
    req_t q;
    q = req_t'({$urandom, $urandom, $urandom, $urandom});
    q.req_type = REQ_EVAL;
    q.now_ms = t;
    q.din_bits = din;
    q.presence = pres;
    return q;
  endfunction

  function automatic req_t wr(logic [3:0] idx, logic en, logic [1:0] trig, logic [1:0] act,
                              logic [2:0] ch, logic [4:0] tgt, logic [31:0] hold,
                              logic [15:0] off);
    req_t q;
    q.req_type = REQ_WRITE;
    q.now_ms = $urandom;
    q.din_bits = 8'($urandom);
    q.presence = 2'($urandom);
    q.rule_index = idx;
    q.rule_enabled = en;
    q.rule_trigger = trig;
    q.rule_action = act;
    q.rule_channel = ch;
    q.rule_target = tgt;
    q.rule_hold_ms = hold;
    q.rule_linger_s = off;
    return q;
  endfunction

  task automatic send(req_t q, bit typed, rsp_t e);
    int gap;
    rsp_t p;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.data = q;
    do @(posedge clk); while (!in_ch.ready);
    p = predict_relays(q);
    expected_rsp.push_back(typed ? e : p);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    in_ch.valid = 0;
    wait (expected_rsp.size() == 0);
    repeat (40) @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    if (idx == CFG_RULE_COUNT) m_rule_cnt = val[4:0];
    else if (idx == CFG_RELAY_COUNT) m_relay_cnt = val;
    else m_input_cnt = val[3:0];
  endtask

  task automatic set_config(logic [5:0] rc, logic [5:0] lc, logic [5:0] ic);
    write_reg(CFG_RULE_COUNT, rc);
    write_reg(CFG_RELAY_COUNT, lc);
    write_reg(CFG_INPUT_COUNT, ic);
  endtask

  task automatic random_items(int count);
    req_t q;
    logic [31:0] hold;
    logic [15:0] off;
    logic [1:0] act;
    int lim;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        case ($urandom_range(0, 9))
          0, 1: hold = 0;
          2: hold = $urandom;
          default: hold = $urandom_range(0, 1500);
        endcase
        case ($urandom_range(0, 4))
          0: off = 0;
          1: off = 16'($urandom);
          default: off = 16'($urandom_range(0, 3));
        endcase
        act = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(ACT_ON, ACT_OFF)) :
                                           2'($urandom);
        lim = (m_relay_cnt == 0) ? 0 : ((m_relay_cnt > 32) ? 31 : m_relay_cnt - 1);
        q = wr(4'($urandom), $urandom_range(0, 9) != 0, 2'($urandom), act, 3'($urandom),
               ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, lim)) : 5'($urandom),
               hold, off);
      end else begin
        if ($urandom_range(0, 39) == 0) now_t = $urandom;
        else now_t = now_t + $urandom_range(0, 400);
        if ($urandom_range(0, 3) == 0) cur_din = 8'($urandom);
        if ($urandom_range(0, 3) == 0) cur_pres = 2'($urandom);
        q = ev(now_t, cur_din, cur_pres);
      end
      send(q, 0, '0);
    end
  endtask

  initial begin
    row_t table_rows[$];
    row_t row;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_RULE_COUNT;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
    for (int i = 0; i < RULES; i++) begin
      m_rules[i] = '0;
      clear_rule_state(i);
    end
    m_relays = 0;
    m_rule_cnt = 0;
    m_relay_cnt = 0;
    m_input_cnt = 0;
    repeat (11) @(negedge clk);
    rst_n = 1;

    set_config(6'd16, 6'd32, 6'd8);
    row.typed = 1;
    row.r = ev(32'd0, 8'h00, PRES_UNKNOWN);       row.e = '{32'h0, 1'b0}; table_rows.push_back(row);
    row.r = wr(4'd0, 1'b1, TRIG_PRES_ACT, ACT_ON, 3'd0, 5'd0, 32'd0, 16'd1);
    row.e = '{32'h0, 1'b1}; table_rows.push_back(row);
    row.r = wr(4'd1, 1'b1, TRIG_DIN_ACT, ACT_ON, 3'd7, 5'd31, 32'd100, 16'd0);
    row.e = '{32'h0, 1'b1}; table_rows.push_back(row);
    row.r = wr(4'd2, 1'b1, TRIG_DIN_OFF, ACT_OFF, 3'd0, 5'd5, 32'd0, 16'd0);
    row.e = '{32'h0, 1'b1}; table_rows.push_back(row);
    row.r = wr(4'd3, 1'b1, TRIG_PRES_OFF, ACT_ON, 3'd3, 5'd5, 32'd0, 16'hFFFF);
    row.e = '{32'h0, 1'b1}; table_rows.push_back(row);
    row.r = wr(4'd15, 1'b1, TRIG_PRES_ACT, ACT_BAD2, 3'd0, 5'd1, 32'd0, 16'd0);
    row.e = '{32'h0, 1'b0}; table_rows.push_back(row);
    row.r = wr(4'd14, 1'b1, TRIG_PRES_ACT, ACT_BAD3, 3'd0, 5'd1, 32'd0, 16'd0);
    row.e = '{32'h0, 1'b0}; table_rows.push_back(row);
    row.r = wr(4'd13, 1'b0, TRIG_PRES_ACT, ACT_ON, 3'd0, 5'd2, 32'd0, 16'd0);
    row.e = '{32'h0, 1'b0}; table_rows.push_back(row);
    row.r = wr(4'd12, 1'b1, TRIG_DIN_ACT, ACT_ON, 3'd6, 5'd9, 32'hFFFFFFFF, 16'd5);
    row.e = '{32'h0, 1'b1}; table_rows.push_back(row);
    row.typed = 0;
    row.e = '0;
    row.r = ev(32'd10, 8'h80, PRES_HERE);          table_rows.push_back(row);
    row.r = ev(32'd110, 8'hC0, PRES_HERE);         table_rows.push_back(row);
    row.r = ev(32'd200, 8'hFF, PRES_UNKNOWN);      table_rows.push_back(row);
    row.r = ev(32'd300, 8'h7F, PRES_AWAY);         table_rows.push_back(row);
    row.r = ev(32'd900, 8'h00, PRES_BAD);          table_rows.push_back(row);
    row.r = ev(32'd1500, 8'h01, PRES_HERE);        table_rows.push_back(row);
    row.r = ev(32'hFFFFFFF0, 8'h81, PRES_HERE); table_rows.push_back(row);
    row.r = ev(32'h00000010, 8'h40, PRES_AWAY); table_rows.push_back(row);
    row.r = ev(32'h00001000, 8'h40, PRES_UNKNOWN); table_rows.push_back(row);
    row.r = ev(32'h7FFFFFFF, 8'hFE, PRES_AWAY); table_rows.push_back(row);
    row.r = ev(32'h80000000, 8'h00, PRES_HERE); table_rows.push_back(row);
    foreach (table_rows[i]) send(table_rows[i].r, table_rows[i].typed, table_rows[i].e);

    random_items(75);
    in_ch.valid = 0;
    wait (expected_rsp.size() == 0);
    @(negedge clk);
    random_items(75);
    set_config(6'd31, 6'd63, 6'd15);
    random_items(150);
    set_config(6'd0, 6'd0, 6'd0);
    random_items(40);
    set_config(6'd6, 6'd10, 6'd3);
    random_items(150);
    set_config(6'd17, 6'd33, 6'd9);
    random_items(100);
    set_config(6'($urandom_range(1, 16)), 6'($urandom_range(1, 32)),
               6'($urandom_range(0, 8)));
    random_items(140);
    in_ch.valid = 0;

    wait (expected_rsp.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      out_ch.ready = 0;
      repeat (stall) @(negedge clk);
      out_ch.ready = 1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rsp.size() == 0) begin
        report("unexpected transaction", out_ch.data.relay_bits, 0);
      end else begin
        e = expected_rsp.pop_front();
        if (out_ch.data.relay_bits !== e.relay_bits)
          report("relay_bits", out_ch.data.relay_bits, e.relay_bits);
        if (out_ch.data.rule_kept !== e.rule_kept)
          report("rule_kept", 32'(out_ch.data.rule_kept), 32'(e.rule_kept));
      end
    end
  end

endmodule
